@@ src/ils_pkg.sv @@
// Shared types and constants for the indexed list store.
package ils_pkg;

    localparam int DEPTH  = 16;
    localparam int WORD_W = 32;
    localparam int POS_W  = 4;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    // compare width wide enough for both position and count
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

    localparam logic signed [WORD_W-1:0] WORD_EMPTY = '1;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH   = 2'd0,
        FN_POP    = 2'd1,
        FN_INSERT = 2'd2,
        FN_REMOVE = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LOWER,
        CELL_FROM_UPPER
    } t_cell_op;

    typedef struct packed {
        t_status            status;
        logic [CNT_W-1:0]   count;
        logic               pop_ok;
        logic [IDX_W-1:0]   pop_idx;
    } t_ctl_res;

endpackage

@@ src/indexed_list_store_unit.sv @@
// Top level of the indexed list store: cell row, control and output register.
//
// Ordered list of up to DEPTH signed 32-bit words held in a row of cells.
// Input channel (i_valid / o_stall) carries one request item: i_func selects
// push at end, pop from end, insert at i_position, or remove at i_position.
// Output channel (o_valid / i_stall) returns one result item per request:
// o_word_out (popped word, -1 on empty pop, else 0), o_count (elements after
// the request) and o_status (done, full, empty, index out of range).
// o_valid rises in the cycle after acceptance. Throughput is one item
// per cycle while the receiver does not stall: every cell shifts, loads or
// holds in the same cycle, so an insert or remove at any index shifts the row
// at once. A pop reads the top word through one DEPTH-to-one mux at the index
// just below the fill count. While the receiver stalls, the result register
// holds its item; o_stall rises only when that register is full and stalled,
// so a new item is taken in the same cycle the old one leaves.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending
// result; stored words are not cleared and are never read before written.
module indexed_list_store_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [ils_pkg::FUNC_W-1:0]            i_func,
    input  logic [ils_pkg::POS_W-1:0]             i_position,
    input  logic signed [ils_pkg::WORD_W-1:0]     i_word_in,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [ils_pkg::WORD_W-1:0]     o_word_out,
    output logic [ils_pkg::CNT_W-1:0]             o_count,
    output logic [ils_pkg::STAT_W-1:0]            o_status
);
    import ils_pkg::*;

    logic                     fire;
    t_cell_op                 ops   [DEPTH];
    logic signed [WORD_W-1:0] slots [DEPTH];
    t_ctl_res                 res;

    logic                     r_valid;
    logic                     n_valid;
    logic signed [WORD_W-1:0] r_word;
    logic signed [WORD_W-1:0] n_word;
    logic [CNT_W-1:0]         r_count;
    logic [STAT_W-1:0]        r_status;

    assign o_stall = r_valid && i_stall;
    assign fire    = i_valid && !o_stall;

    ils_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_func     (i_func),
        .i_position (i_position),
        .o_ops      (ops),
        .o_res      (res)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [WORD_W-1:0] lower;
        logic signed [WORD_W-1:0] upper;
        if (g == 0) begin : g_first
            assign lower = '0;
        end else begin : g_mid_lo
            assign lower = slots[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign upper = '0;
        end else begin : g_mid_hi
            assign upper = slots[g+1];
        end
        ils_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (ops[g]),
            .i_load  (i_word_in),
            .i_lower (lower),
            .i_upper (upper),
            .o_word  (slots[g])
        );
    end

    always_comb begin
        if (res.pop_ok) begin
            n_word = slots[res.pop_idx];
        end else if (res.status == ST_EMPTY) begin
            n_word = WORD_EMPTY;
        end else begin
            n_word = '0;
        end
    end

    assign n_valid = fire || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // load result payload on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_word   <= n_word;
            r_count  <= res.count;
            r_status <= res.status;
        end
    end

    assign o_valid    = r_valid;
    assign o_word_out = r_word;
    assign o_count    = r_count;
    assign o_status   = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count <= CNT_W'(DEPTH)))
        else $error("count above capacity");

    a_fire_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_valid)
        else $error("accepted item produced no result");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_word_out == WORD_EMPTY && o_count == '0))
        else $error("empty result inconsistent");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_count == CNT_W'(DEPTH)))
        else $error("full result with spare room");

endmodule

@@ src/ils_cell.sv @@
// One storage cell of the list: holds a word, loads, or takes a neighbor's word.
module ils_cell (
    input  logic                                  i_clk,
    input  ils_pkg::t_cell_op                     i_op,
    input  logic signed [ils_pkg::WORD_W-1:0]     i_load,
    input  logic signed [ils_pkg::WORD_W-1:0]     i_lower,
    input  logic signed [ils_pkg::WORD_W-1:0]     i_upper,
    output logic signed [ils_pkg::WORD_W-1:0]     o_word
);
    import ils_pkg::*;

    logic signed [WORD_W-1:0] r_word;
    logic signed [WORD_W-1:0] n_word;

    always_comb begin
        case (i_op)
            CELL_LOAD:       n_word = i_load;
            CELL_FROM_LOWER: n_word = i_lower;
            CELL_FROM_UPPER: n_word = i_upper;
            default:         n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

@@ src/ils_ctrl.sv @@
// Fill counter and request decode: status, new count and per-cell operations.
module ils_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [ils_pkg::FUNC_W-1:0]    i_func,
    input  logic [ils_pkg::POS_W-1:0]     i_position,
    output ils_pkg::t_cell_op             o_ops [ils_pkg::DEPTH],
    output ils_pkg::t_ctl_res             o_res
);
    import ils_pkg::*;

    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] fill_c;
    logic             full;
    logic             empty;
    logic             do_ins;
    logic             do_rem;
    logic [CMP_W-1:0] ins_at;
    t_status          status;

    assign pos_c  = CMP_W'(i_position);
    assign fill_c = CMP_W'(r_fill);
    assign full   = (r_fill == CNT_W'(DEPTH));
    assign empty  = (r_fill == '0);

    // decode the request
    always_comb begin
        status = ST_DONE;
        n_fill = r_fill;
        do_ins = 1'b0;
        do_rem = 1'b0;
        ins_at = fill_c;
        unique case (t_func'(i_func))
            FN_PUSH: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    n_fill = r_fill + 1'b1;
                end
            end
            FN_POP: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    n_fill = r_fill - 1'b1;
                end
            end
            FN_INSERT: begin
                ins_at = pos_c;
                if (pos_c > fill_c) begin
                    status = ST_RANGE;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    n_fill = r_fill + 1'b1;
                end
            end
            FN_REMOVE: begin
                if (pos_c >= fill_c) begin
                    status = ST_RANGE;
                end else begin
                    do_rem = 1'b1;
                    n_fill = r_fill - 1'b1;
                end
            end
            default: status = ST_DONE;
        endcase
    end

    // cell ops: load at index, shift above it on insert; shift down on remove
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            o_ops[i] = CELL_HOLD;
            if (i_fire && do_ins) begin
                if (CMP_W'(i) == ins_at) begin
                    o_ops[i] = CELL_LOAD;
                end else if (CMP_W'(i) > ins_at) begin
                    o_ops[i] = CELL_FROM_LOWER;
                end
            end else if (i_fire && do_rem) begin
                if (CMP_W'(i) >= pos_c) begin
                    o_ops[i] = CELL_FROM_UPPER;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_fire) begin
            r_fill <= n_fill;
        end
    end

    assign o_res.status  = status;
    assign o_res.count   = n_fill;
    assign o_res.pop_ok  = (t_func'(i_func) == FN_POP) && !empty;
    assign o_res.pop_idx = IDX_W'(r_fill - 1'b1);

endmodule
